// ----- rtl/core/afp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the ASCII decimal to fixed-point parser.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int CH_W        = 8;
  localparam int VAL_W       = 32;
  localparam int FRAC_DIGITS = 3;

  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  localparam int SCALE  = pow10(FRAC_DIGITS);
  localparam int FRAC_W = $clog2(SCALE);
  localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef logic [CH_W-1:0]    ch_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_INT,
    PH_FRAC
  } phase_t;

  // weight of the fraction digit that follows cnt digits already taken
  function automatic frac_t frac_weight(input cnt_t cnt);
    int w;
    w = 1;
    for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
      if (i >= int'(cnt)) begin
        w = w * 10;
      end
    end
    return FRAC_W'(w);
  endfunction

endpackage

// ----- rtl/core/afp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_text_if / afp_result_if
// Valid/ready channels of the parser: character beats in, value beats out.
// ----------------------------------------------------------------------------
interface afp_text_if;
  logic                   valid;
  logic                   ready;
  logic [afp_pkg::CH_W-1:0] ch;
  logic                   start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface afp_result_if;
  logic                          valid;
  logic                          ready;
  logic signed [afp_pkg::VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/core/ascii_fixed_point_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_fixed_point_parser
// Streaming ASCII decimal to signed fixed-point (value x 10^FRAC_DIGITS).
// ----------------------------------------------------------------------------
// One character beat is taken every cycle. Each beat is decoded and folded
// into the running integer and fraction sums and registered; a value
// beat appears on the result channel the cycle after the character that
// ends the number (first non-fitting character, or the last fraction
// digit). The result channel has one output register: the text side stays
// ready while it is empty or being drained, so the rate is one character
// per cycle, set only by back-pressure on the result side.
// ----------------------------------------------------------------------------
module ascii_fixed_point_parser (
  input  logic               clk,
  input  logic               rst,
  afp_text_if.sink           text,
  afp_result_if.source       result
);
  import afp_pkg::*;

  phase_t phase, phase_next, phase_eff;
  val_t   int_acc, int_acc_next, int_eff;   // integer part, pre-scaled
  frac_t  frac_acc, frac_acc_next, frac_eff; // fraction part, pre-weighted
  cnt_t   frac_cnt, frac_cnt_next, cnt_eff;
  logic   negative, negative_next, neg_eff;

  logic   out_valid;
  val_t   out_value, out_value_next;

  logic   beat, is_digit, emit, take_int, take_frac, set_neg;
  logic [3:0] digit;

  assign beat        = text.valid && text.ready;
  assign text.ready  = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.value = out_value;

  assign is_digit  = (text.ch >= CH_ZERO) && (text.ch <= CH_NINE);
  assign digit     = 4'(text.ch - CH_ZERO);
  assign phase_eff = text.start_req ? PH_LEAD : phase;
  assign int_eff   = text.start_req ? '0 : int_acc;
  assign frac_eff  = text.start_req ? '0 : frac_acc;
  assign cnt_eff   = text.start_req ? '0 : frac_cnt;
  assign neg_eff   = text.start_req ? 1'b0 : negative;

  // next state
  always_comb begin
    phase_next = phase_eff;
    emit       = 1'b0;
    take_int   = 1'b0;
    take_frac  = 1'b0;
    set_neg    = 1'b0;
    unique case (phase_eff)
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      PH_LEAD: begin
        if (text.ch == CH_SPACE || text.ch == CH_TAB) begin
          phase_next = PH_LEAD;
        end else if (text.ch == CH_MINUS) begin
          set_neg    = 1'b1;
          phase_next = PH_INT;
        end else if (is_digit) begin
          take_int   = 1'b1;
          phase_next = PH_INT;
        end else if (text.ch == CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          take_int = 1'b1;
        end else if (text.ch == CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          take_frac = 1'b1;
          if (cnt_eff == CNT_W'(FRAC_DIGITS - 1)) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end
        end else begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    val_t sum;
    int_acc_next  = int_eff;
    frac_acc_next = frac_eff;
    frac_cnt_next = cnt_eff;
    negative_next = neg_eff || set_neg;
    if (take_int) begin
      int_acc_next = (int_eff << 3) + (int_eff << 1) + VAL_W'(digit) * VAL_W'(SCALE);
    end
    if (take_frac) begin
      frac_acc_next = frac_eff + FRAC_W'(digit) * frac_weight(cnt_eff);
      frac_cnt_next = cnt_eff + CNT_W'(1);
    end
    sum            = int_acc_next + VAL_W'(frac_acc_next);
    out_value_next = negative_next ? (val_t'(0) - sum) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      int_acc   <= '0;
      frac_acc  <= '0;
      frac_cnt  <= '0;
      negative  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (beat) begin
        phase    <= phase_next;
        int_acc  <= int_acc_next;
        frac_acc <= frac_acc_next;
        frac_cnt <= frac_cnt_next;
        negative <= negative_next;
      end
      if (beat && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat && emit) begin
      out_value <= out_value_next;
    end
  end

endmodule

// ----- rtl/core/afp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_checker
// Port-level checks of the parser, bound into every parser instance.
// ----------------------------------------------------------------------------
module afp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       text_valid,
  input logic                       text_ready,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [afp_pkg::VAL_W-1:0]  result_value
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_value))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> result_valid && !result_ready)
    else $error("text side stalled without a held result");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !(text_valid && text_ready) |=> !result_valid)
    else $error("result beat without a character beat");

endmodule

bind ascii_fixed_point_parser afp_checker u_afp_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_value (result.value)
);

// ----- tb/afp_value_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_value_checker
// Watches the character and value channels of the parser. Every accepted
// character beat is folded into a local model of the parse, and the values
// it closes are queued. Every value beat is checked against the oldest one.
// ----------------------------------------------------------------------------
module afp_value_checker
  import afp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  afp_text_if   text,
  afp_result_if result,
  output int    errors,
  output int    pending
);

  phase_t ph;
  val_t   acc_int;
  val_t   acc_frac;
  int     n_frac;
  logic   neg;
  val_t   expected_values[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic is_digit(input ch_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic val_t close_number();
    val_t scale;
    val_t f;
    val_t r;
    scale = 1;
    f     = acc_frac;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      scale = scale * 10;
    end
    for (int i = n_frac; i < FRAC_DIGITS; i++) begin
      f = f * 10;
    end
    r = acc_int * scale + f;
    if (neg) begin
      r = -r;
    end
    ph = PH_IDLE;
    return r;
  endfunction

  task automatic fold_char(input ch_t c, input logic s, output logic done, output val_t v);
    done = 1'b0;
    v    = '0;
    if (s) begin
      acc_int  = '0;
      acc_frac = '0;
      n_frac   = 0;
      neg      = 1'b0;
      ph       = PH_LEAD;
    end
    if (ph == PH_LEAD) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        return;
      end
      if (c == CH_MINUS) begin
        neg = 1'b1;
        ph  = PH_INT;
        return;
      end
      ph = PH_INT;
    end
    case (ph)
      PH_INT: begin
        if (is_digit(c)) begin
          acc_int = acc_int * 10 + val_t'(c - CH_ZERO);
        end else if (c == CH_POINT) begin
          ph = PH_FRAC;
        end else begin
          done = 1'b1;
          v    = close_number();
        end
      end
      PH_FRAC: begin
        if (is_digit(c)) begin
          acc_frac = acc_frac * 10 + val_t'(c - CH_ZERO);
          n_frac++;
          if (n_frac >= FRAC_DIGITS) begin
            done = 1'b1;
            v    = close_number();
          end
        end else begin
          done = 1'b1;
          v    = close_number();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    logic done;
    val_t v;
    val_t want;
    if (rst) begin
      ph       = PH_IDLE;
      acc_int  = '0;
      acc_frac = '0;
      n_frac   = 0;
      neg      = 1'b0;
      expected_values.delete();
    end else begin
      // a value beat always belongs to a character taken at an earlier edge
      if (result.valid && result.ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value beat %0d with nothing expected", result.value));
        end else begin
          want = expected_values.pop_front();
          if (result.value !== want) begin
            report_mismatch($sformatf("value got %0d (%h) want %0d (%h)",
                                      result.value, result.value,
                                      $signed(want), want));
          end
        end
      end
      if (text.valid && text.ready) begin
        fold_char(text.ch, text.start_req, done, v);
        if (done) begin
          expected_values.push_back(v);
        end
      end
    end
    pending = expected_values.size();
  end

endmodule

// ----- tb/ascii_fixed_point_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_fixed_point_parser_tb
// Drives character beats into the parser: a short directed set covering
// signs, lone sign and point, spaces after the sign, restarts mid-number
// and ignored text, then random numbers with noise, random idling on both
// channels and a long hold-off on the value side. A separate checker
// predicts and compares every value beat.
// ----------------------------------------------------------------------------
module ascii_fixed_point_parser_tb;
  import afp_pkg::*;

  localparam ch_t CH_NUL      = 8'h00;
  localparam ch_t CH_TOP      = 8'hff;
  localparam int  RAND_BEATS  = 800;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   beats_sent;
  int   cycle_count;
  logic opening;

  afp_text_if   text ();
  afp_result_if result ();

  ascii_fixed_point_parser dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result)
  );

  afp_value_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // opening marks the first beat of a number
  task automatic send_beat(input ch_t c);
    logic steady;
    steady = (beats_sent >= 100) && (beats_sent < 250);
    if (!steady && $urandom_range(0, 99) < 15) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid     <= 1'b1;
    text.ch        <= c;
    text.start_req <= opening;
    opening = 1'b0;
    do @(posedge clk); while (!(text.valid && text.ready));
    beats_sent++;
  endtask

  task automatic send_digit();
    send_beat(ch_t'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_number();
    int n_int;
    int n_frac;
    opening = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
    if ($urandom_range(0, 2) == 0) begin
      send_beat(CH_MINUS);
    end
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (n_int) send_digit();
    if ($urandom_range(0, 3) != 0) begin
      send_beat(CH_POINT);
      n_frac = $urandom_range(0, FRAC_DIGITS + 1);
      repeat (n_frac) send_digit();
    end
    case ($urandom_range(0, 9))
      0: ;
      1: send_beat(CH_NUL);
      2: send_beat(CH_SPACE);
      default: send_beat(ch_t'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) send_beat(ch_t'($urandom_range(0, 255)));
    end
  endtask

  // value side: random idling, a quiet stretch, and one long hold-off
  initial begin : drain
    int   hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (!held && beats_sent >= 300) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        result.ready <= 1'b0;
      end else if (beats_sent >= 500 && beats_sent < 650) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int target;
    clk            = 1'b0;
    rst            = 1'b1;
    beats_sent     = 0;
    opening        = 1'b0;
    text.valid     = 1'b0;
    text.ch        = CH_NUL;
    text.start_req = 1'b0;
    result.ready   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ignored while idle
    send_beat(CH_TOP);
    // tab, sign, lone point, NUL
    opening = 1'b1;
    send_beat(CH_TAB);
    send_beat(CH_MINUS);
    send_beat(CH_POINT);
    send_beat(CH_NUL);
    // space after the sign ends the number
    opening = 1'b1;
    send_beat(CH_MINUS);
    send_beat(CH_SPACE);
    // restart drops the open number
    opening = 1'b1;
    send_beat(ch_t'(CH_ZERO + 1));
    send_beat(ch_t'(CH_ZERO + 2));
    opening = 1'b1;
    send_beat(CH_NINE);
    send_beat(CH_POINT);
    send_beat(CH_NINE);
    send_beat(CH_NINE);
    send_beat(CH_NINE);
    send_beat(ch_t'(CH_ZERO + 5));
    opening = 1'b1;
    send_beat(CH_POINT);
    send_beat(ch_t'(CH_ZERO + 7));
    send_beat(CH_TOP);
    opening = 1'b1;
    send_beat(CH_TOP);
    opening = 1'b1;
    send_beat(CH_NUL);

    target = beats_sent + RAND_BEATS;
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        opening = 1'($urandom_range(0, 1));
        send_beat(ch_t'($urandom_range(0, 255)));
      end else begin
        send_number();
      end
    end
    text.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
